// ===== rtl/ehft_pkg.sv =====
`timescale 1ns / 1ps
package ehft_pkg;
   localparam int MaxHooksDefault = 16;

   localparam logic [1:0] FUNC_REGISTER   = 2'd0;
   localparam logic [1:0] FUNC_UNREGISTER = 2'd1;
   localparam logic [1:0] FUNC_NOTIFY     = 2'd2;
   localparam logic [1:0] FUNC_RESERVED   = 2'd3;

   localparam logic [2:0] ST_REGISTERED  = 3'd0;
   localparam logic [2:0] ST_INVALID     = 3'd1;
   localparam logic [2:0] ST_FULL        = 3'd2;
   localparam logic [2:0] ST_REMOVED     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd4;
   localparam logic [2:0] ST_MATCHED     = 3'd5;
   localparam logic [2:0] ST_NO_RECEIVER = 3'd6;

   localparam int SKIP_PROC_BIT   = 0;
   localparam int SKIP_THREAD_BIT = 1;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] event_code;
      logic [31:0] range_low;
      logic [31:0] range_high;
      logic [31:0] process_filter;
      logic [31:0] thread_filter;
      logic        skip_own_process;
      logic        skip_own_thread;
      logic [31:0] source_thread;
      logic        callback_present;
      logic [31:0] target_handle;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] hook_handle;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] handle;
      logic [31:0] range_low;
      logic [31:0] range_high;
      logic [31:0] process_filter;
      logic [31:0] thread_filter;
      logic [31:0] owner_thread;
      logic [1:0]  skip_flags;
   } entry_type;
endpackage

// ===== rtl/ehft_front.sv =====
`timescale 1ns / 1ps
module ehft_front
   import ehft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [255:0] req_tdata,
   output logic        q_valid,
   input  logic        q_ready,
   output cmd_type     q_cmd
);
   localparam int Depth = 2;
   cmd_type    mem_ff [Depth];
   cmd_type    cmd;
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign cmd.func             = req_tdata[1:0];
   assign cmd.event_code       = req_tdata[33:2];
   assign cmd.range_low        = req_tdata[65:34];
   assign cmd.range_high       = req_tdata[97:66];
   assign cmd.process_filter   = req_tdata[129:98];
   assign cmd.thread_filter    = req_tdata[161:130];
   assign cmd.skip_own_process = req_tdata[162];
   assign cmd.skip_own_thread  = req_tdata[163];
   assign cmd.source_thread    = req_tdata[195:164];
   assign cmd.callback_present = req_tdata[196];
   assign cmd.target_handle    = req_tdata[228:197];

   assign req_tready = (cnt_ff != 2'd2);
   // drop the reserved func code at the door
   assign push  = req_tvalid && req_tready && (cmd.func != FUNC_RESERVED);
   assign pop   = q_valid && q_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd   = mem_ff[rp_ff];
   assign wp_in  = push ? ~wp_ff : wp_ff;
   assign rp_in  = pop ? ~rp_ff : rp_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= cmd;
   end
endmodule

// ===== rtl/ehft_back.sv =====
`timescale 1ns / 1ps
module ehft_back
   import ehft_pkg::*;
#(
   parameter int MAX_HOOKS = MaxHooksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] own_process_id,
   input  logic        q_valid,
   output logic        q_ready,
   input  cmd_type     q_cmd,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output rsp_type     rsp
);
   localparam int IW = (MAX_HOOKS > 1) ? $clog2(MAX_HOOKS) : 1;
   localparam int CW = $clog2(MAX_HOOKS + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_EMIT} state_type;

   state_type     state_ff;
   entry_type     tab_ff [MAX_HOOKS];
   logic [CW-1:0] count_ff;
   logic [31:0]   next_handle_ff;
   logic [IW-1:0] idx_ff;
   cmd_type       cmd_ff;
   logic          found_ff;
   rsp_type       out_ff;
   logic          out_valid_ff;
   logic          pend_ff;
   rsp_type       pend_data_ff;

   entry_type     e;
   logic          accepts;
   logic          at_end;
   logic [31:0]   nh;
   logic          out_free;

   assign e = tab_ff[idx_ff];
   assign accepts = !e.skip_flags[SKIP_PROC_BIT]
      && !(e.skip_flags[SKIP_THREAD_BIT] && cmd_ff.source_thread == e.owner_thread)
      && cmd_ff.event_code >= e.range_low && cmd_ff.event_code <= e.range_high
      && (e.process_filter == 32'd0 || e.process_filter == own_process_id)
      && (e.thread_filter == 32'd0 || e.thread_filter == cmd_ff.source_thread);
   assign at_end = (CW'(idx_ff) + CW'(1)) >= count_ff;
   assign nh = (next_handle_ff + 32'd1 == 32'd0) ? 32'd1 : next_handle_ff + 32'd1;
   assign out_free = !out_valid_ff || rsp_tready;
   assign q_ready = (state_ff == S_IDLE) && out_free;
   assign rsp_tvalid = out_valid_ff;
   assign rsp = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         next_handle_ff <= 32'd1;
         out_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid && out_free) begin
                  cmd_ff   <= q_cmd;
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  pend_ff  <= 1'b0;
                  case (q_cmd.func)
                     FUNC_REGISTER: begin
                        out_valid_ff <= 1'b1;
                        if (!q_cmd.callback_present || q_cmd.range_low > q_cmd.range_high)
                           out_ff <= '{ST_INVALID, 32'd0, 1'b1};
                        else if (count_ff >= CW'(MAX_HOOKS))
                           out_ff <= '{ST_FULL, 32'd0, 1'b1};
                        else begin
                           out_ff <= '{ST_REGISTERED, next_handle_ff, 1'b1};
                           tab_ff[count_ff[IW-1:0]] <= '{next_handle_ff,
                              q_cmd.range_low, q_cmd.range_high, q_cmd.process_filter,
                              q_cmd.thread_filter, q_cmd.source_thread,
                              {q_cmd.skip_own_thread, q_cmd.skip_own_process}};
                           count_ff       <= count_ff + 1'b1;
                           next_handle_ff <= nh;
                        end
                     end
                     FUNC_UNREGISTER, FUNC_NOTIFY: begin
                        state_ff <= S_SCAN;
                     end
                     default: ;
                  endcase
               end
            end
            S_SCAN: begin
               if (count_ff == '0) begin
                  if (out_free) begin
                     out_valid_ff <= 1'b1;
                     out_ff <= (cmd_ff.func == FUNC_NOTIFY) ?
                        '{ST_NO_RECEIVER, 32'd0, 1'b1} : '{ST_NOT_FOUND, 32'd0, 1'b1};
                     state_ff <= S_IDLE;
                  end
               end else if (cmd_ff.func == FUNC_UNREGISTER) begin
                  if (cmd_ff.target_handle != 32'd0 && e.handle == cmd_ff.target_handle)
                     state_ff <= S_SHIFT;
                  else if (at_end)
                     state_ff <= S_EMIT;
                  else
                     idx_ff <= idx_ff + 1'b1;
               end else if (!(accepts && pend_ff) || out_free) begin
                  // hold one match back so the final one can carry last
                  if (accepts) begin
                     if (pend_ff) begin
                        out_valid_ff <= 1'b1;
                        out_ff       <= pend_data_ff;
                     end
                     pend_ff      <= 1'b1;
                     pend_data_ff <= '{ST_MATCHED, e.handle, 1'b0};
                     found_ff     <= 1'b1;
                  end
                  if (at_end) state_ff <= S_EMIT;
                  else idx_ff <= idx_ff + 1'b1;
               end
            end
            S_SHIFT: begin
               if (at_end) begin
                  count_ff <= count_ff - 1'b1;
                  found_ff <= 1'b1;
                  state_ff <= S_EMIT;
               end else begin
                  tab_ff[idx_ff] <= tab_ff[idx_ff + 1'b1];
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  if (cmd_ff.func == FUNC_UNREGISTER)
                     out_ff <= found_ff ? '{ST_REMOVED, 32'd0, 1'b1}
                                        : '{ST_NOT_FOUND, 32'd0, 1'b1};
                  else if (pend_ff)
                     out_ff <= '{ST_MATCHED, pend_data_ff.hook_handle, 1'b1};
                  else
                     out_ff <= '{ST_NO_RECEIVER, 32'd0, 1'b1};
                  pend_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/event_hook_filter_table_top.sv =====
`timescale 1ns / 1ps
// Event subscription filter table.
// req_ channel carries one command transaction: register, unregister or
// notify. rsp_ channel returns status transactions; rsp_tlast marks the
// final one for a command. Register gives one response, registered once the
// command leaves the queue. Unregister scans the table one entry per cycle
// up to the match and then closes the gap one entry per cycle.
// Notify tests one stored hook per cycle while the response output can
// take a held match, and streams each match; the scan is the limiting loop.
// A two-entry command queue lets req_ accept while the table is busy.
// Func code 3 is dropped at the input with no response.
// csr_we writes own_process_id; write it only while idle.
// Synchronous reset empties the table, sets the next handle to 1 and
// clears own_process_id. When rsp_tready is low the pending response holds
// and the table engine stalls, then the queue fills and req_tready drops.
module event_hook_filter_table_top
   import ehft_pkg::*;
#(
   parameter int MAX_HOOKS = MaxHooksDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // func, event_code, range_low, range_high, process_filter, thread_filter,
   // skip_own_process, skip_own_thread, source_thread, callback_present,
   // target_handle, zero fill
   input  logic [231:0] req_tdata,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, hook_handle, zero fill
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast
);
   logic [31:0] own_pid_ff;
   logic        q_valid, q_ready;
   cmd_type     q_cmd;
   rsp_type     r;

   always_ff @(posedge clock) begin
      if (reset) own_pid_ff <= 32'd0;
      else if (csr_we) own_pid_ff <= csr_wdata;
   end

   ehft_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata({24'd0, req_tdata}),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   ehft_back #(.MAX_HOOKS(MAX_HOOKS)) u_back (
      .clock(clock), .reset(reset), .own_process_id(own_pid_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp(r)
   );

   assign rsp_tdata = {5'd0, r.hook_handle, r.status};
   assign rsp_tlast = r.last;
endmodule
